/* sv/lcr_pkg.sv */
// ----------------------------------------------------------------------------
// Lattice coefficient rounding: shared types
// Operation codes and the side information that travels down the pipeline
// next to the arithmetic of each item.
// ----------------------------------------------------------------------------
package lcr_pkg;

	// Width of the high and low result fields.
	localparam int OUT_W = 20;

	// Function select carried in the operation field.
	typedef enum logic [1:0] {
		OP_POWER2ROUND = 2'd0,
		OP_DECOMPOSE   = 2'd1,
		OP_HINT_GEN    = 2'd2,
		OP_HINT_APPLY  = 2'd3
	} lcr_op_t;

	// Per-item information worked out at entry and carried to the output.
	typedef struct packed {
		lcr_op_t                   op;
		logic                      hint;
		logic                      neg;
		logic                      flag;
		logic signed [OUT_W-1:0]   p2r_high;
		logic signed [OUT_W-1:0]   p2r_low;
	} side_t;

endpackage

/* sv/lattice_coefficient_rounding_core.sv */
// ----------------------------------------------------------------------------
// Lattice coefficient rounding core
// Power2round, decompose, hint generation and hint application on one
// coefficient per cycle while the output is not held.
// ----------------------------------------------------------------------------
// Usage
// The input channel takes one item (operation, value, high_in, hint) at each
// rising edge with in_valid high and in_stall low. The output channel shows
// one result item (high, low, hint_out) per input item, in order, under
// out_valid; the receiver holds it with out_stall.
// The pipeline has one entry stage, one stage per trial subtraction of the
// shifted modulus, a sign fix-up stage, one stage per trial subtraction of
// the shifted 2*HALF_STEP, a centring stage and the output register. A new
// item enters in every cycle while in_stall is low; the chain of constant
// trial subtractions, one per stage, sets the depth and keeps every stage
// to a single compare and subtract.
// Reset clears every stage's valid bit, so no result appears until an item
// has gone all the way through. While a result waits with out_stall high the
// whole pipeline holds and in_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lattice_coefficient_rounding_core #(
	parameter int MODULUS   = 8380417,
	parameter int DROP_BITS = 13,
	parameter int HALF_STEP = 261888,
	parameter int HIGH_MAX  = 15
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             operation,
	input  logic signed [31:0]                     value,
	input  logic [5:0]                             high_in,
	input  logic                                   hint,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [lcr_pkg::OUT_W-1:0]       high,
	output logic signed [lcr_pkg::OUT_W-1:0]       low,
	output logic                                   hint_out
);
	import lcr_pkg::*;

	// Derived sizes of the two constant divisions.
	localparam longint MOD_L     = longint'(MODULUS);
	localparam longint TWO_L     = 2 * longint'(HALF_STEP);
	localparam int     MB        = $clog2(MOD_L + 64'sd1);
	localparam int     TB        = $clog2(TWO_L + 64'sd1);
	localparam int     MOD_STEPS = 33 - MB;
	localparam int     DIV_STEPS = (MB > TB) ? (MB - TB + 1) : 1;
	localparam int     QW        = DIV_STEPS;
	localparam int     HW        = QW + 1;
	localparam int     LW        = TB + 1;
	localparam bit     CORNER_OK = (((MOD_L - 1) % TWO_L) == 0);
	localparam longint CORNER_Q  = (MOD_L - 1) / TWO_L;
	localparam logic [DROP_BITS:0] P2R_BIAS = (DROP_BITS+1)'((64'sd1 <<< (DROP_BITS - 1)) - 1);

	// Whole pipeline moves unless a finished result is held at the output.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// ------------------------------------------------------------------
	// Entry stage: magnitude for the modular path, power2round and hint
	// generation.
	// ------------------------------------------------------------------
	logic signed [32:0]        p2r_sum;
	logic signed [32:0]        p2r_hi;
	logic signed [DROP_BITS:0] p2r_lo;
	logic signed [32:0]        val_w;
	logic                      mk_flag;
	side_t                     side_in;

	always_comb begin
		val_w   = 33'(value);
		p2r_sum = val_w + 33'(signed'({1'b0, P2R_BIAS}));
		p2r_hi  = p2r_sum >>> DROP_BITS;
		// The low part is the dropped bits less the rounding bias.
		p2r_lo  = signed'({1'b0, p2r_sum[DROP_BITS-1:0]}) - signed'(P2R_BIAS);
		mk_flag = (val_w > 33'(HALF_STEP)) || (val_w < -33'(HALF_STEP)) ||
			((val_w == -33'(HALF_STEP)) && (high_in != 6'd0));
		side_in.op       = lcr_op_t'(operation);
		side_in.hint     = hint;
		side_in.neg      = value[31];
		side_in.flag     = mk_flag;
		side_in.p2r_high = OUT_W'(p2r_hi);
		side_in.p2r_low  = OUT_W'(p2r_lo);
	end

	logic        vld_s1;
	logic [31:0] abs_s1;
	side_t       side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			abs_s1  <= value[31] ? (32'd0 - value) : value;
			side_s1 <= side_in;
		end
	end

	// ------------------------------------------------------------------
	// Magnitude mod MODULUS: one trial subtraction of MODULUS << k a stage.
	// ------------------------------------------------------------------
	logic        vld_s2  [MOD_STEPS];
	logic [31:0] rem_s2  [MOD_STEPS];
	side_t       side_s2 [MOD_STEPS];

	for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
		localparam int         K   = MOD_STEPS - 1 - j;
		localparam logic [63:0] SUB = 64'(MOD_L) << K;
		logic        vin;
		logic [31:0] rin;
		logic [31:0] rnext;
		side_t       sin;

		if (j == 0) begin : g_first
			assign vin = vld_s1;
			assign rin = abs_s1;
			assign sin = side_s1;
		end else begin : g_next
			assign vin = vld_s2[j-1];
			assign rin = rem_s2[j-1];
			assign sin = side_s2[j-1];
		end

		always_comb begin
			if ({32'd0, rin} >= SUB) begin
				rnext = rin - SUB[31:0];
			end else begin
				rnext = rin;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[j] <= 1'b0;
			end else if (adv) begin
				vld_s2[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s2[j]  <= rnext;
				side_s2[j] <= sin;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sign fix-up: a negative value maps to MODULUS minus its remainder.
	// ------------------------------------------------------------------
	logic [MB-1:0] mrem;
	assign mrem = rem_s2[MOD_STEPS-1][MB-1:0];

	logic          vld_s3;
	logic [MB-1:0] m_s3;
	side_t         side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2[MOD_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_s2[MOD_STEPS-1].neg && (mrem != '0)) begin
				m_s3 <= MB'(MOD_L) - mrem;
			end else begin
				m_s3 <= mrem;
			end
			side_s3 <= side_s2[MOD_STEPS-1];
		end
	end

	// ------------------------------------------------------------------
	// Division by 2*HALF_STEP: quotient bit k decided in each stage.
	// ------------------------------------------------------------------
	logic          vld_s4  [DIV_STEPS];
	logic [MB-1:0] rem_s4  [DIV_STEPS];
	logic [QW-1:0] quo_s4  [DIV_STEPS];
	side_t         side_s4 [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int          K   = DIV_STEPS - 1 - j;
		localparam logic [63:0] SUB = 64'(TWO_L) << K;
		logic          vin;
		logic [MB-1:0] rin;
		logic [QW-1:0] qin;
		logic [MB-1:0] rnext;
		logic [QW-1:0] qnext;
		side_t         sin;

		if (j == 0) begin : g_first
			assign vin = vld_s3;
			assign rin = m_s3;
			assign qin = '0;
			assign sin = side_s3;
		end else begin : g_next
			assign vin = vld_s4[j-1];
			assign rin = rem_s4[j-1];
			assign qin = quo_s4[j-1];
			assign sin = side_s4[j-1];
		end

		always_comb begin
			if ({(64-MB)'(0), rin} >= SUB) begin
				rnext = rin - SUB[MB-1:0];
				qnext = qin | (QW'(1) << K);
			end else begin
				rnext = rin;
				qnext = qin;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s4[j] <= 1'b0;
			end else if (adv) begin
				vld_s4[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s4[j]  <= rnext;
				quo_s4[j]  <= qnext;
				side_s4[j] <= sin;
			end
		end
	end

	// ------------------------------------------------------------------
	// Centring: a remainder above HALF_STEP becomes negative and the high
	// part goes up by one. The top corner folds back to zero.
	// ------------------------------------------------------------------
	logic [MB-1:0]        r2;
	logic [QW-1:0]        q2;
	logic                 up;
	logic signed [LW-1:0] r2_s;
	logic signed [LW-1:0] l_c;
	logic [HW-1:0]        hi_c;
	logic                 corner;

	always_comb begin
		r2     = rem_s4[DIV_STEPS-1];
		q2     = quo_s4[DIV_STEPS-1];
		up     = 64'(r2) > 64'(HALF_STEP);
		r2_s   = signed'(LW'(r2));
		l_c    = up ? (r2_s - LW'(TWO_L)) : r2_s;
		hi_c   = HW'(q2) + HW'(up);
		corner = CORNER_OK && (64'(hi_c) == 64'(CORNER_Q));
	end

	logic                 vld_s5;
	logic [HW-1:0]        hi_s5;
	logic signed [LW-1:0] lo_s5;
	side_t                side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hi_s5   <= corner ? '0 : hi_c;
			lo_s5   <= corner ? (l_c - LW'(1)) : l_c;
			side_s5 <= side_s4[DIV_STEPS-1];
		end
	end

	// ------------------------------------------------------------------
	// Hint step and result selection into the output register.
	// ------------------------------------------------------------------
	logic signed [OUT_W-1:0] hi_dec;
	logic signed [OUT_W-1:0] lo_dec;
	logic signed [OUT_W-1:0] hi_use;
	logic signed [OUT_W-1:0] high_d;
	logic signed [OUT_W-1:0] low_d;
	logic                    flag_d;
	logic                    lo_pos;

	always_comb begin
		hi_dec = OUT_W'(hi_s5);
		lo_dec = OUT_W'(lo_s5);
		lo_pos = !lo_s5[LW-1] && (lo_s5 != '0);
		hi_use = hi_dec;
		if (side_s5.hint) begin
			if (lo_pos) begin
				hi_use = (64'(hi_s5) == 64'(HIGH_MAX)) ? '0 : (hi_dec + OUT_W'(1));
			end else begin
				hi_use = (hi_s5 == '0) ? OUT_W'(HIGH_MAX) : (hi_dec - OUT_W'(1));
			end
		end
		case (side_s5.op)
			OP_POWER2ROUND: begin
				high_d = side_s5.p2r_high;
				low_d  = side_s5.p2r_low;
				flag_d = 1'b0;
			end
			OP_DECOMPOSE: begin
				high_d = hi_dec;
				low_d  = lo_dec;
				flag_d = 1'b0;
			end
			OP_HINT_GEN: begin
				high_d = '0;
				low_d  = '0;
				flag_d = side_s5.flag;
			end
			default: begin
				high_d = hi_use;
				low_d  = '0;
				flag_d = 1'b0;
			end
		endcase
	end

	logic                    vld_s6;
	logic signed [OUT_W-1:0] high_s6;
	logic signed [OUT_W-1:0] low_s6;
	logic                    flag_s6;
	lcr_op_t                 op_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			high_s6 <= high_d;
			low_s6  <= low_d;
			flag_s6 <= flag_d;
			op_s6   <= side_s5.op;
		end
	end

	assign out_valid = vld_s6;
	assign high      = high_s6;
	assign low       = low_s6;
	assign hint_out  = flag_s6;

	// ------------------------------------------------------------------
	// Checks on the internal arithmetic and the hold behaviour.
	// ------------------------------------------------------------------

	// The reduced value always lies below the modulus.
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (64'(m_s3) < 64'(MOD_L)))
		else $error("reduced coefficient not below the modulus");

	// The centred low part stays within [-HALF_STEP, HALF_STEP].
	a_low_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> ((longint'(lo_s5) >= -longint'(HALF_STEP)) &&
			(longint'(lo_s5) <= longint'(HALF_STEP))))
		else $error("centred low part out of range");

	// Only a hint generation item can carry a set hint bit out.
	a_hint_op: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hint_out) |-> (op_s6 == OP_HINT_GEN))
		else $error("hint bit set on an item other than hint generation");

	// A held output freezes the entry stage as well.
	a_hold_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(vld_s1))
		else $error("entry stage moved while the output was held");

endmodule
